>>> hdl/gks_pkg.sv
package gks_pkg;
    localparam int MAX_HALF_WIDTH_DEF = 6;
    localparam int SAMPLE_BITS_DEF    = 32;
    localparam int WEIGHT_BITS        = 16;
    localparam int N_WEIGHTS          = 7;
    localparam int CFG_IDX_BITS       = 3;
    localparam int CFG_DATA_BITS      = 16;
    localparam int HALF_BITS          = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH = 3'd0;

    localparam logic [HALF_BITS-1:0]   HALF_RESET = 3'd2;
    localparam logic [WEIGHT_BITS-1:0] W0_RESET   = 16'd32768;
    localparam logic [WEIGHT_BITS-1:0] W1_RESET   = 16'd4435;
    localparam logic [WEIGHT_BITS-1:0] W2_RESET   = 16'd11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MAC,
        ST_DIV,
        ST_OUT
    } state_t;
endpackage

>>> hdl/gks_divider.sv
module gks_divider #(
    parameter int NUM_BITS = 68,
    parameter int DEN_BITS = 20,
    parameter int Q_BITS   = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                busy,
    output logic                done,
    output logic [Q_BITS-1:0]   quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] num_reg, num_next;
    logic [DEN_BITS:0]   rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg;
    logic [Q_BITS-1:0]   q_reg, q_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg, done_reg;
    logic [DEN_BITS:0]   trial;
    logic                ge;

    // restoring division, one bit per cycle
    always_comb
    begin
        trial    = {rem_reg[DEN_BITS-1:0], num_reg[NUM_BITS-1]};
        ge       = (rem_reg[DEN_BITS] == 1'b1) || (trial >= {1'b0, den_reg});
        rem_next = ge ? (trial - {1'b0, den_reg}) : trial;
        num_next = {num_reg[NUM_BITS-2:0], 1'b0};
        q_next   = {q_reg[Q_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;
endmodule

>>> hdl/gaussian_kernel_smoother.sv
// A result leaves once h newer requests arrive or the record ends; each result passes
// through a check, multiply-accumulate steps over the taps, a divide and an output step.
// One request at a time: no new sample is accepted until its results have left, output
// stalls included. The bit-serial divider and the shared multiplier set the rate. Reset
// (rst_n, async, active low) clears control state and loads the register defaults; the
// sample window holds no reset value.
module gaussian_kernel_smoother #(
    parameter int MAX_HALF_WIDTH = gks_pkg::MAX_HALF_WIDTH_DEF,
    parameter int SAMPLE_BITS    = gks_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gks_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [gks_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [SAMPLE_BITS-1:0]            sample_value,
    input  logic                              last_sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [SAMPLE_BITS-1:0]            smoothed_value,
    output logic                              last_result
);
    import gks_pkg::*;

    localparam int DEPTH    = 2 * MAX_HALF_WIDTH + 1;
    localparam int POS_BITS = $clog2(DEPTH + 1);
    localparam int PROD_BITS = SAMPLE_BITS + WEIGHT_BITS;
    localparam int ACC_BITS = PROD_BITS + 4;
    localparam int DEN_BITS = WEIGHT_BITS + 4;
    localparam int D_BITS   = $clog2(MAX_HALF_WIDTH + 1);

    state_t state_reg, state_next;

    logic [HALF_BITS-1:0]   half_reg;
    logic [WEIGHT_BITS-1:0] weight_reg [N_WEIGHTS];
    logic [SAMPLE_BITS-1:0] win_reg [DEPTH];
    logic [3:0]             rcv_reg;
    logic [POS_BITS-1:0]    nout_reg;
    logic                   last_reg;
    logic [POS_BITS-1:0]    c_reg;
    logic [D_BITS-1:0]      d_reg;
    logic                   side_reg;
    logic [ACC_BITS-1:0]    acc_reg;
    logic [DEN_BITS-1:0]    den_reg;
    logic [PROD_BITS-1:0]   prod_reg;
    logic                   prod_v_reg;
    logic [SAMPLE_BITS-1:0] res_reg;
    logic                   res_last_reg;

    logic [D_BITS-1:0]      h_eff;
    logic                   emit;
    logic [POS_BITS:0]      pos;
    logic                   tap_ok;
    logic                   mac_end;
    logic [WEIGHT_BITS-1:0] w_cur;
    logic [SAMPLE_BITS-1:0] s_cur;
    logic                   div_start;
    logic                   div_busy;
    logic                   div_done;
    logic [SAMPLE_BITS-1:0] quot;

    assign h_eff = (half_reg > HALF_BITS'(MAX_HALF_WIDTH)) ? D_BITS'(MAX_HALF_WIDTH)
                                                          : D_BITS'(half_reg);
    assign emit = (nout_reg != '0) &&
                  (last_reg || (nout_reg > POS_BITS'(h_eff)));

    always_comb
    begin
        w_cur = weight_reg[d_reg];
        if (!side_reg)
            pos = {1'b0, c_reg} - (POS_BITS+1)'(d_reg);
        else
            pos = {1'b0, c_reg} + (POS_BITS+1)'(d_reg);
        if (!side_reg)
            tap_ok = (POS_BITS'(d_reg) <= c_reg);
        else
            tap_ok = (d_reg != '0) && (pos < (POS_BITS+1)'(rcv_reg))
                     && (pos < (POS_BITS+1)'(DEPTH));
        s_cur = win_reg[pos[POS_BITS-1:0] < POS_BITS'(DEPTH) ?
                        pos[$clog2(DEPTH)-1:0] : '0];
        mac_end = side_reg && (d_reg == h_eff);
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        in_ready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_CHECK;
            ST_CHECK: state_next = emit ? ST_MAC : ST_IDLE;
            ST_MAC:
            begin
                if (mac_end)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!prod_v_reg && !div_busy && !div_done && den_reg != '0)
                    div_start = 1'b1;
                if (den_reg == '0 && !prod_v_reg)
                    state_next = ST_OUT;
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:   if (out_ready) state_next = ST_CHECK;
            default:  state_next = ST_IDLE;
        endcase
    end

    gks_divider #(
        .NUM_BITS (ACC_BITS),
        .DEN_BITS (DEN_BITS),
        .Q_BITS   (SAMPLE_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_reg),
        .den   (den_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            half_reg  <= HALF_RESET;
            weight_reg[0] <= W0_RESET;
            weight_reg[1] <= W1_RESET;
            weight_reg[2] <= W2_RESET;
            for (int i = 3; i < N_WEIGHTS; i++)
                weight_reg[i] <= '0;
            rcv_reg    <= '0;
            nout_reg   <= '0;
            last_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_HALF_WIDTH)
                    half_reg <= cfg_data[HALF_BITS-1:0];
                else
                    weight_reg[cfg_index - 1'b1] <= cfg_data;
            end
            prod_v_reg <= (state_reg == ST_MAC) && tap_ok;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg <= last_sample;
                        if (rcv_reg != 4'd15)
                            rcv_reg <= rcv_reg + 1'b1;
                        if (nout_reg != POS_BITS'(DEPTH))
                            nout_reg <= nout_reg + 1'b1;
                    end
                end
                ST_CHECK:
                begin
                    if (!emit && last_reg)
                    begin
                        rcv_reg  <= '0;
                        nout_reg <= '0;
                        last_reg <= 1'b0;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                        nout_reg <= nout_reg - 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            for (int k = DEPTH - 1; k > 0; k--)
                win_reg[k] <= win_reg[k-1];
            win_reg[0] <= sample_value;
        end
        if (state_reg == ST_CHECK)
        begin
            c_reg    <= nout_reg - 1'b1;
            d_reg    <= '0;
            side_reg <= 1'b0;
            acc_reg  <= '0;
            den_reg  <= '0;
        end
        if (state_reg == ST_MAC)
        begin
            prod_reg <= s_cur * w_cur;
            if (tap_ok)
                den_reg <= den_reg + DEN_BITS'(w_cur);
            if (side_reg)
                d_reg <= d_reg + 1'b1;
            side_reg <= ~side_reg;
        end
        if (prod_v_reg)
            acc_reg <= acc_reg + ACC_BITS'(prod_reg);
        if (state_reg == ST_DIV)
        begin
            if (den_reg == '0)
                res_reg <= '0;
            else if (div_done)
                res_reg <= quot;
            res_last_reg <= last_reg && (c_reg == '0);
        end
    end

    assign out_valid      = (state_reg == ST_OUT);
    assign smoothed_value = res_reg;
    assign last_result    = res_last_reg;

`ifndef ASSERT_OFF
    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> state_reg == ST_DIV)
        else $error("divider started outside ST_DIV");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !in_ready)
        else $error("input ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(smoothed_value))
        else $error("result changed while stalled");
`endif
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import gks_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } sample_req_t;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } smooth_res_t;

    localparam int WIN_DEPTH = 13;
    localparam int REG_WEIGHT_0 = 1;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [31:0]              sample_value;
    logic                     last_sample;
    logic                     out_valid;
    logic                     out_ready;
    logic [31:0]              smoothed_value;
    logic                     last_result;

    sample_req_t pending_samples[$];
    smooth_res_t expected_smooth[$];

    // predictor state
    logic [31:0] win_samples[WIN_DEPTH];
    int          rec_count;
    int          unsent_count;
    logic [2:0]  cur_half;
    logic [15:0] cur_weight[N_WEIGHTS];

    int  mismatch_count;
    int  gap_left;
    int  burst_left;
    int  stall_phase;
    bit  in_taken;

    gaussian_kernel_smoother i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_value   (sample_value),
        .last_sample    (last_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .smoothed_value (smoothed_value),
        .last_result    (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic void enqueue_sample(sample_req_t req);
        pending_samples = {pending_samples, req};
    endfunction

    function automatic void enqueue_result(smooth_res_t res);
        expected_smooth = {expected_smooth, res};
    endfunction

    function automatic logic [31:0] smooth_at(int c, int h);
        logic [67:0] acc;
        logic [19:0] wsum;
        logic [67:0] quot;
        acc = '0;
        wsum = '0;
        for (int d = 0; d <= h; d++)
        begin
            if (d <= c && c - d < WIN_DEPTH)
            begin
                acc += 68'(win_samples[c - d]) * 68'(cur_weight[d]);
                wsum += 20'(cur_weight[d]);
            end
            if (d != 0 && c + d < rec_count && c + d < WIN_DEPTH)
            begin
                acc += 68'(win_samples[c + d]) * 68'(cur_weight[d]);
                wsum += 20'(cur_weight[d]);
            end
        end
        if (wsum == 0)
            return '0;
        quot = acc / 68'(wsum);
        return quot[31:0];
    endfunction

    task automatic predict_sample(sample_req_t req);
        int h;
        int c;
        smooth_res_t res;
        h = (cur_half > 6) ? 6 : int'(cur_half);
        for (int k = WIN_DEPTH - 1; k > 0; k--)
            win_samples[k] = win_samples[k - 1];
        win_samples[0] = req.value;
        if (rec_count < 15)
            rec_count++;
        if (unsent_count < WIN_DEPTH)
            unsent_count++;
        while (unsent_count > 0 && (req.last || unsent_count > h))
        begin
            c = unsent_count - 1;
            res.value = smooth_at(c, h);
            res.last = req.last && c == 0;
            enqueue_result(res);
            unsent_count--;
        end
        if (req.last)
        begin
            rec_count = 0;
            unsent_count = 0;
        end
    endtask

    task automatic write_reg(int idx, int val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = CFG_IDX_BITS'(idx);
        cfg_data = CFG_DATA_BITS'(val);
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_HALF_WIDTH)
            cur_half = 3'(val);
        else
            cur_weight[idx - REG_WEIGHT_0] = 16'(val);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        while ((pending_samples.size() != 0 || expected_smooth.size() != 0
                || in_valid) && guard < 400000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (300) @(negedge clk);
    endtask

    task automatic add_record(int len, int mode);
        sample_req_t req;
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0: req.value = $urandom();
                1: req.value = 32'hFFFF_FFFF;
                2: req.value = '0;
                default: req.value = $urandom_range(0, 32'h00FF_FFFF);
            endcase
            req.last = (i == len - 1);
            enqueue_sample(req);
        end
    endtask

    task automatic random_weights(bit extreme);
        for (int d = 0; d < N_WEIGHTS; d++)
        begin
            if (extreme)
                write_reg(REG_WEIGHT_0 + d, ($urandom_range(0, 1) != 0) ? 16'hFFFF : 0);
            else
                write_reg(REG_WEIGHT_0 + d, $urandom_range(0, 32768));
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_taken)
            begin
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_samples.size() != 0)
            begin
                in_valid <= 1'b1;
                sample_value <= pending_samples[0].value;
                last_sample <= pending_samples[0].last;
                void'(pending_samples.pop_front());
                if (burst_left <= 0)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
            stall_phase <= stall_phase + 1;
            case (stall_phase[9:8])
                2'd0: out_ready <= 1'b1;
                2'd1: out_ready <= ($urandom_range(0, 3) != 0);
                2'd2: out_ready <= (stall_phase[4:2] != 3'd0);
                default: out_ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // request accept and result check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
                predict_sample('{value: sample_value, last: last_sample});
            if (out_valid && out_ready)
            begin
                if (expected_smooth.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h last %b", smoothed_value, last_result);
                end
                else
                begin
                    if (expected_smooth[0].value !== smoothed_value
                        || expected_smooth[0].last !== last_result)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp %h/%b got %h/%b",
                                     expected_smooth[0].value, expected_smooth[0].last,
                                     smoothed_value, last_result);
                    end
                    void'(expected_smooth.pop_front());
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        sample_value = '0;
        last_sample = 1'b0;
        out_ready = 1'b0;
        mismatch_count = 0;
        gap_left = 0;
        burst_left = 0;
        stall_phase = 0;
        in_taken = 1'b0;
        rec_count = 0;
        unsent_count = 0;
        cur_half = HALF_RESET;
        cur_weight = '{W0_RESET, W1_RESET, W2_RESET, 16'd0, 16'd0, 16'd0, 16'd0};
        for (int k = 0; k < WIN_DEPTH; k++)
            win_samples[k] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset weights, extremes, single-sample and long records
        add_record(1, 1);
        add_record(5, 1);
        add_record(4, 2);
        add_record(15, 0);
        wait_idle();

        write_reg(REG_HALF_WIDTH, 6);
        for (int d = 0; d < N_WEIGHTS; d++)
            write_reg(REG_WEIGHT_0 + d, (d == 3) ? 16'hFFFF : 0);
        add_record(3, 1);
        add_record(12, 0);
        wait_idle();

        write_reg(REG_HALF_WIDTH, 0);
        write_reg(REG_WEIGHT_0, 32768);
        add_record(3, 0);
        wait_idle();
        write_reg(REG_HALF_WIDTH, 7);
        add_record(14, 1);
        wait_idle();

        // half-width shrunk mid-record
        write_reg(REG_HALF_WIDTH, 6);
        add_record(8, 0);
        wait_idle();
        enqueue_sample('{value: 32'h1234_5678, last: 1'b0});
        enqueue_sample('{value: 32'h8000_0000, last: 1'b0});
        enqueue_sample('{value: 32'h0000_0001, last: 1'b0});
        wait_idle();
        write_reg(REG_HALF_WIDTH, 1);
        add_record(3, 0);
        wait_idle();

        // random phases
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(REG_HALF_WIDTH, $urandom_range(0, 7));
            random_weights(ph % 5 == 4);
            for (int r = 0; r < 6; r++)
                add_record(($urandom_range(0, 3) == 0) ? $urandom_range(8, 16)
                                                       : $urandom_range(1, 7),
                           $urandom_range(0, 5));
            wait_idle();
        end

        if (mismatch_count == 0 && expected_smooth.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
